/* sv/bpcl_pkg.sv */
package bpcl_pkg;

  localparam int unsigned FRAMES = 64;
  localparam int unsigned HASH_BUCKETS = 16;
  localparam int unsigned PAGE_NUMBER_BITS = 32;

  localparam int unsigned FrameBits = $clog2(FRAMES);
  localparam int unsigned BucketBits = $clog2(HASH_BUCKETS);
  localparam int unsigned UseBits = FrameBits + 1;
  localparam int unsigned ProbeBits = FrameBits + 2;
  localparam int unsigned PinBits = 15;
  localparam int unsigned EntryBits = PAGE_NUMBER_BITS + PinBits + 2 * FrameBits;

  typedef logic [FrameBits-1:0] frame_t;
  typedef logic [BucketBits-1:0] bucket_t;
  typedef logic [PAGE_NUMBER_BITS-1:0] page_t;
  typedef logic [PinBits-1:0] pins_t;

  localparam pins_t PinMax = '1;
  localparam logic [ProbeBits-1:0] ProbeLimit = ProbeBits'(2 * FRAMES);

  typedef enum logic [1:0] {
    CmdPin   = 2'd0,
    CmdUnpin = 2'd1,
    CmdDirty = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StHit    = 3'd0,
    StUnused = 3'd1,
    StVictim = 3'd2,
    StNoVic  = 3'd3,
    StDone   = 3'd4
  } status_e;

  typedef struct packed {
    page_t  page;
    pins_t  pins;
    frame_t next;
    frame_t prev;
  } entry_t;

  typedef enum logic [4:0] {
    SIdle,
    SHeadRd,
    SWalkRd,
    SWalkChk,
    SHitWr,
    SLinkHdRd,
    SLinkHdWait,
    SLinkWr,
    SProbeRd,
    SProbeChk,
    SUnlPrevRd,
    SUnlPrevWr,
    SUnlNextRd,
    SUnlNextWr,
    SUpdRd,
    SUpdWr,
    SOut
  } state_e;

  function automatic bucket_t bucket_of(page_t p);
    return p[BucketBits-1:0];
  endfunction

endpackage

/* sv/buffer_pool_clock_lookup_unit.sv */
// Channel  Direction  Signals
// in       sink       in_valid_i, in_ready_o, cmd_i, page_number_i, frame_i, load_from_store_i
// out      source     out_valid_o, out_ready_i, status_o, frame_out_o, writeback_*, load_request_o,
//                     fetch_page_o
// A mark-dirty sets the frame's dirty bit and delivers; an unpin sets the clock bit, reads the
// frame entry and writes back its pin count less one (never below zero). A pin reads the bucket
// head and walks the chain, and on a hit adds one pin; a miss takes an unused frame or probes
// with the clock hand (skipping frame 0), unlinks a victim, then links and writes the new entry, all through the
// frame-table memory port. One word is handled at a time; the result register holds while
// out_ready_i is low and a new word is taken only after it is delivered. Reset clears clock
// and dirty bits, bucket heads, the frame count and the hand at once; no clearing pass is needed.
module buffer_pool_clock_lookup_unit
  import bpcl_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  cmd_i,
  input  logic [PAGE_NUMBER_BITS-1:0] page_number_i,
  input  logic [5:0]                  frame_i,
  input  logic                        load_from_store_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic [5:0]                  frame_out_o,
  output logic                        writeback_valid_o,
  output logic [31:0]                 writeback_page_o,
  output logic                        load_request_o,
  output logic [31:0]                 fetch_page_o
);

  state_e state_q, state_d;
  logic [1:0] cmd_q, cmd_d;
  page_t page_q, page_d;
  logic [5:0] fr_q, fr_d;
  logic load_q, load_d;
  frame_t cur_q, cur_d, vic_q, vic_d, hand_q, hand_d;
  logic [UseBits-1:0] used_q, used_d, steps_q, steps_d;
  logic [ProbeBits-1:0] probes_q, probes_d;
  entry_t vent_q, vent_d;
  logic [2:0] st_q, st_d;
  logic wbv_q, wbv_d;
  page_t wbp_q, wbp_d;
  logic lreq_q, lreq_d;
  logic [FRAMES-1:0] clk_bits_q, clk_bits_d, dirty_q, dirty_d;
  frame_t head_q [HASH_BUCKETS];
  logic head_we;
  bucket_t head_wa;
  frame_t head_wd;

  logic we;
  frame_t waddr, raddr;
  entry_t wdata, rdata;
  logic [EntryBits-1:0] rdata_raw;
  bucket_t bkt;

  assign rdata = entry_t'(rdata_raw);
  assign bkt = bucket_of(page_q);

  bpcl_ram #(.Width(EntryBits), .Depth(FRAMES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      used_q     <= '0;
      hand_q     <= '0;
      clk_bits_q <= '0;
      dirty_q    <= '0;
      for (int i = 0; i < HASH_BUCKETS; i++) head_q[i] <= '0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      hand_q     <= hand_d;
      clk_bits_q <= clk_bits_d;
      dirty_q    <= dirty_d;
      if (head_we) head_q[head_wa] <= head_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; page_q <= page_d; fr_q <= fr_d; load_q <= load_d;
    cur_q <= cur_d; vic_q <= vic_d; steps_q <= steps_d; probes_q <= probes_d;
    vent_q <= vent_d; st_q <= st_d; wbv_q <= wbv_d; wbp_q <= wbp_d; lreq_q <= lreq_d;
  end

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; page_d = page_q; fr_d = fr_q; load_d = load_q;
    cur_d = cur_q; vic_d = vic_q; steps_d = steps_q; probes_d = probes_q; vent_d = vent_q;
    st_d = st_q; wbv_d = wbv_q; wbp_d = wbp_q; lreq_d = lreq_q;
    used_d = used_q; hand_d = hand_q; clk_bits_d = clk_bits_q; dirty_d = dirty_q;
    head_we = 1'b0; head_wa = bkt; head_wd = '0;
    we = 1'b0; waddr = cur_q; wdata = rdata; raddr = cur_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d = cmd_i; page_d = page_number_i; fr_d = frame_i; load_d = load_from_store_i;
          st_d = StDone; wbv_d = 1'b0; wbp_d = '0; lreq_d = 1'b0; vic_d = '0;
          unique case (cmd_e'(cmd_i))
            CmdPin: state_d = SHeadRd;
            CmdUnpin: begin
              if ({1'b0, frame_i} < 7'(FRAMES)) begin
                cur_d = frame_t'(frame_i);
                clk_bits_d[frame_t'(frame_i)] = 1'b1;
                state_d = SUpdRd;
              end else state_d = SOut;
            end
            CmdDirty: begin
              if ({1'b0, frame_i} < 7'(FRAMES)) dirty_d[frame_t'(frame_i)] = 1'b1;
              state_d = SOut;
            end
            default: state_d = SOut;
          endcase
        end
      end
      SHeadRd: begin
        cur_d = head_q[bkt]; steps_d = '0; state_d = SWalkRd;
      end
      SWalkRd: begin
        raddr = cur_q;
        if (cur_q == '0 || steps_q == UseBits'(FRAMES)) state_d = SLinkHdRd;
        else state_d = SWalkChk;
      end
      SWalkChk: begin
        if (rdata.page == page_q) begin
          state_d = SHitWr;
        end else begin
          cur_d = rdata.next; steps_d = steps_q + 1'b1; state_d = SWalkRd;
        end
      end
      SHitWr: begin
        we = 1'b1; waddr = cur_q; wdata = rdata;
        if (rdata.pins != PinMax) wdata.pins = rdata.pins + 1'b1;
        st_d = StHit; vic_d = cur_q; state_d = SOut;
      end
      SLinkHdRd: begin
        if (used_q + 1'b1 < UseBits'(FRAMES)) begin
          used_d = used_q + 1'b1;
          vic_d = frame_t'(used_q + 1'b1);
          st_d = StUnused; lreq_d = load_q;
          state_d = SLinkHdWait;
        end else begin
          probes_d = '0; state_d = SProbeRd;
        end
      end
      SProbeRd: begin
        if (probes_q == ProbeLimit) begin
          st_d = StNoVic; state_d = SOut;
        end else begin
          raddr = hand_q; cur_d = hand_q;
          hand_d = hand_q + 1'b1; probes_d = probes_q + 1'b1;
          state_d = (hand_q == '0) ? SProbeRd : SProbeChk;
        end
      end
      SProbeChk: begin
        if (bucket_of(rdata.page) == bkt) begin
          state_d = SProbeRd;
        end else if (rdata.pins != '0 || clk_bits_q[cur_q]) begin
          clk_bits_d[cur_q] = 1'b0; state_d = SProbeRd;
        end else begin
          vic_d = cur_q; vent_d = rdata; st_d = StVictim; lreq_d = load_q;
          if (dirty_q[cur_q]) begin
            wbv_d = 1'b1; wbp_d = rdata.page; dirty_d[cur_q] = 1'b0;
          end
          if (rdata.prev != '0) begin
            state_d = SUnlPrevRd;
          end else begin
            head_we = 1'b1; head_wa = bucket_of(rdata.page); head_wd = rdata.next;
            state_d = SUnlNextRd;
          end
        end
      end
      SUnlPrevRd: begin
        raddr = vent_q.prev; state_d = SUnlPrevWr;
      end
      SUnlPrevWr: begin
        we = 1'b1; waddr = vent_q.prev; wdata = rdata; wdata.next = vent_q.next;
        state_d = SUnlNextRd;
      end
      SUnlNextRd: begin
        raddr = vent_q.next;
        state_d = (vent_q.next != '0) ? SUnlNextWr : SLinkHdWait;
      end
      SUnlNextWr: begin
        we = 1'b1; waddr = vent_q.next; wdata = rdata; wdata.prev = vent_q.prev;
        state_d = SLinkHdWait;
      end
      SLinkHdWait: begin
        cur_d = head_q[bkt]; raddr = head_q[bkt];
        state_d = SLinkWr;
      end
      SLinkWr: begin
        if (cur_q != '0) begin
          we = 1'b1; waddr = cur_q; wdata = rdata; wdata.prev = vic_q;
        end
        clk_bits_d[vic_q] = 1'b0;
        head_we = 1'b1; head_wa = bkt; head_wd = vic_q;
        vent_d.page = page_q; vent_d.pins = pins_t'(1); vent_d.next = cur_q; vent_d.prev = '0;
        state_d = SUpdWr;
      end
      SUpdRd: begin
        raddr = cur_q; state_d = SUpdWr;
      end
      SUpdWr: begin
        we = 1'b1;
        if (cmd_q == CmdUnpin) begin
          waddr = cur_q; wdata = rdata;
          if (rdata.pins != '0) wdata.pins = rdata.pins - 1'b1;
        end else begin
          waddr = vic_q; wdata = vent_q;
        end
        state_d = SOut;
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assign out_valid_o = (state_q == SOut);
  assign status_o = st_q;
  assign frame_out_o = (st_q == StHit || st_q == StUnused || st_q == StVictim) ?
                       6'(vic_q) : 6'd0;
  assign writeback_valid_o = wbv_q;
  assign writeback_page_o = 32'(wbp_q);
  assign load_request_o = lreq_q;
  assign fetch_page_o = lreq_q ? 32'(page_q) : 32'd0;

endmodule

/* sv/bpcl_ram.sv */
module bpcl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* sv/bpcl_checker.sv */
module bpcl_checker
  import bpcl_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic [5:0] frame_out_o,
  input logic       writeback_valid_o,
  input logic       load_request_o
);

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
  a_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && writeback_valid_o |-> status_o == StVictim)
    else $error("writeback without victim");
  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StNoVic || status_o == StDone) |->
    frame_out_o == 6'd0 && !load_request_o) else $error("frame without pin");

endmodule

bind buffer_pool_clock_lookup_unit bpcl_checker u_bpcl_checker (.*);
